### src/i2cmap_pkg.sv
`timescale 1ns / 1ps

package i2cmap_pkg;

	typedef enum logic [2:0] {
		CMD_START_WR = 3'd0,
		CMD_START_RD = 3'd1,
		CMD_RX_BYTE  = 3'd2,
		CMD_TX_REQ   = 3'd3,
		CMD_STOP     = 3'd4,
		CMD_LOCAL_WR = 3'd5,
		CMD_LOCAL_RD = 3'd6
	} cmd_t;

	localparam logic [7:0] CMD_FLAG = 8'h80;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic [4:0] local_addr;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_data;
		logic       command_valid;
		logic [7:0] command_code;
		logic [7:0] local_data;
		logic       bus_active;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic set_mode;
		logic clr_mode;
		logic set_active;
		logic clr_active;
		logic rx_push;
		logic clr_rx;
		logic map_rd_ptr;
		logic map_rd_local;
		logic map_wr_local;
		logic map_wr_burst;
		logic st_rd_first;
		logic st_rd_next;
		logic cap_first;
		logic apply_single;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic mode;
		logic cnt_zero;
		logic cnt_one;
		logic burst_last;
		logic out_busy;
	} sts_t;

endpackage

### src/i2cmap_ctrl.sv
`timescale 1ns / 1ps

module i2cmap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  i2cmap_pkg::sts_t  sts,
	output i2cmap_pkg::ctl_t  ctl
);
	import i2cmap_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_RDMAP = 5'b00100,
		ST_FIRST = 5'b01000,
		ST_BURST = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl        = '0;
		state_d    = state_q;
		item_stall = !((state_q == ST_IDLE) && !sts.out_busy);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && !item_stall) begin
					ctl.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.cmd)
					CMD_START_WR: begin
						ctl.set_mode   = 1'b1;
						ctl.set_active = 1'b1;
						ctl.out_load   = 1'b1;
						state_d        = ST_IDLE;
					end
					CMD_START_RD: begin
						ctl.clr_mode   = 1'b1;
						ctl.set_active = 1'b1;
						ctl.map_rd_ptr = 1'b1;
						state_d        = ST_RDMAP;
					end
					CMD_RX_BYTE: begin
						ctl.rx_push  = 1'b1;
						ctl.out_load = 1'b1;
						state_d      = ST_IDLE;
					end
					CMD_TX_REQ: begin
						ctl.map_rd_ptr = 1'b1;
						state_d        = ST_RDMAP;
					end
					CMD_STOP: begin
						if (sts.mode && !sts.cnt_zero) begin
							ctl.st_rd_first = 1'b1;
							state_d         = ST_FIRST;
						end else begin
							ctl.clr_rx     = sts.mode;
							ctl.clr_active = 1'b1;
							ctl.out_load   = 1'b1;
							state_d        = ST_IDLE;
						end
					end
					CMD_LOCAL_WR: begin
						ctl.map_wr_local = 1'b1;
						ctl.out_load     = 1'b1;
						state_d          = ST_IDLE;
					end
					CMD_LOCAL_RD: begin
						ctl.map_rd_local = 1'b1;
						state_d          = ST_RDMAP;
					end
					default: begin
						ctl.out_load = 1'b1;
						state_d      = ST_IDLE;
					end
				endcase
			end
			ST_RDMAP: begin
				ctl.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_FIRST: begin
				ctl.cap_first = 1'b1;
				if (sts.cnt_one) begin
					ctl.apply_single = 1'b1;
					ctl.clr_rx       = 1'b1;
					ctl.clr_active   = 1'b1;
					ctl.out_load     = 1'b1;
					state_d          = ST_IDLE;
				end else begin
					ctl.st_rd_next = 1'b1;
					state_d        = ST_BURST;
				end
			end
			ST_BURST: begin
				ctl.map_wr_burst = 1'b1;
				if (sts.burst_last) begin
					ctl.clr_rx     = 1'b1;
					ctl.clr_active = 1'b1;
					ctl.out_load   = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					ctl.st_rd_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/i2cmap_dp.sv
`timescale 1ns / 1ps

module i2cmap_dp #(
	parameter int NUM_REGS = 32,
	parameter int RX_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cmap_pkg::in_item_t  item,
	input  i2cmap_pkg::ctl_t      ctl,
	output i2cmap_pkg::sts_t      sts,
	output logic                  result_valid,
	input  logic                  result_stall,
	output i2cmap_pkg::out_item_t result
);
	import i2cmap_pkg::*;

	localparam int         MAW   = $clog2(NUM_REGS);
	localparam int         SAW   = $clog2(RX_DEPTH);
	localparam int         KW    = $clog2(RX_DEPTH + 1);
	localparam logic [7:0] NUM_B = 8'(NUM_REGS);

	in_item_t       item_q;
	logic           mode_q;
	logic           active_q;
	logic           active_d;
	logic [SAW-1:0] idx_q;
	logic [7:0]     cnt_q;
	logic [MAW-1:0] rp_q;
	logic [7:0]     first_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  pk_q;

	logic [7:0]          map_mem [NUM_REGS];
	logic [NUM_REGS-1:0] map_vld_q;
	logic [7:0]          map_rd_s1;
	logic                map_rv_s1;
	logic [7:0]          st_mem [RX_DEPTH];
	logic [7:0]          st_rd_s1;

	logic [7:0]     loc8;
	logic           loc_in;
	logic [MAW-1:0] map_ra;
	logic           map_re;
	logic [7:0]     ba;
	logic           burst_we;
	logic           map_we;
	logic [MAW-1:0] map_wa;
	logic [7:0]     map_wd;
	logic           st_re;
	logic [SAW-1:0] st_ra;
	logic [8:0]     pk1;
	logic [7:0]     rd_val;
	logic           is_tx;
	logic           cv;
	out_item_t      out_d;
	out_item_t      out_q;
	logic           out_valid_q;

	assign loc8   = {3'b000, item_q.local_addr};
	assign loc_in = loc8 < NUM_B;
	assign map_re = ctl.map_rd_ptr || ctl.map_rd_local;
	assign map_ra = ctl.map_rd_ptr ? rp_q : loc8[MAW-1:0];

	assign ba       = first_q + 8'(pk_q) - 8'd1;
	assign burst_we = ctl.map_wr_burst && (ba < NUM_B);
	assign map_we   = burst_we || (ctl.map_wr_local && loc_in);
	assign map_wa   = ctl.map_wr_burst ? ba[MAW-1:0] : loc8[MAW-1:0];
	assign map_wd   = ctl.map_wr_burst ? st_rd_s1 : item_q.data_byte;

	assign st_re = ctl.st_rd_first || ctl.st_rd_next;
	always_comb begin
		if (ctl.st_rd_first || (k_q >= KW'(RX_DEPTH))) begin
			st_ra = '0;
		end else begin
			st_ra = k_q[SAW-1:0];
		end
	end

	assign pk1 = 9'(pk_q) + 9'd1;

	always_comb begin
		active_d = active_q;
		if (ctl.set_active) begin
			active_d = 1'b1;
		end
		if (ctl.clr_active) begin
			active_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_s1 <= map_mem[map_ra];
			map_rv_s1 <= map_vld_q[map_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rx_push) begin
			st_mem[idx_q] <= item_q.data_byte;
		end
		if (st_re) begin
			st_rd_s1 <= st_mem[st_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			item_q <= item;
		end
		if (ctl.cap_first) begin
			first_q <= st_rd_s1;
		end
		if (ctl.st_rd_first) begin
			k_q <= KW'(1);
		end else if (ctl.st_rd_next) begin
			k_q  <= k_q + KW'(1);
			pk_q <= k_q;
		end
		if (ctl.out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q   <= '0;
			mode_q      <= 1'b1;
			active_q    <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (map_we) begin
				map_vld_q[map_wa] <= 1'b1;
			end
			if (ctl.set_mode) begin
				mode_q <= 1'b1;
			end else if (ctl.clr_mode) begin
				mode_q <= 1'b0;
			end
			active_q <= active_d;
			if (ctl.clr_rx) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (ctl.rx_push) begin
				idx_q <= (idx_q == SAW'(RX_DEPTH - 1)) ? '0 : idx_q + SAW'(1);
				if (cnt_q != 8'hFF) begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
			if (ctl.map_rd_ptr) begin
				rp_q <= (rp_q == MAW'(NUM_REGS - 1)) ? '0 : rp_q + MAW'(1);
			end else if (ctl.apply_single && (st_rd_s1 < NUM_B)) begin
				rp_q <= st_rd_s1[MAW-1:0];
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rd_val = map_rv_s1 ? map_rd_s1 : 8'd0;
	assign is_tx  = (cmd_t'(item_q.cmd) == CMD_START_RD) || (cmd_t'(item_q.cmd) == CMD_TX_REQ);
	assign cv     = ctl.apply_single && (st_rd_s1 >= NUM_B) && ((st_rd_s1 & CMD_FLAG) != 8'd0);

	always_comb begin
		out_d.tx_valid      = is_tx;
		out_d.tx_data       = is_tx ? rd_val : 8'd0;
		out_d.command_valid = cv;
		out_d.command_code  = cv ? st_rd_s1 : 8'd0;
		out_d.local_data    = ((cmd_t'(item_q.cmd) == CMD_LOCAL_RD) && loc_in) ? rd_val : 8'd0;
		out_d.bus_active    = active_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign sts.cmd        = cmd_t'(item_q.cmd);
	assign sts.mode       = mode_q;
	assign sts.cnt_zero   = (cnt_q == 8'd0);
	assign sts.cnt_one    = (cnt_q == 8'd1);
	assign sts.burst_last = (pk1 >= {1'b0, cnt_q}) || (pk1 >= 9'(RX_DEPTH));
	assign sts.out_busy   = out_valid_q && result_stall;

endmodule

### src/i2c_slave_register_map_unit.sv
`timescale 1ns / 1ps

// Byte-level I2C target front end with a byte register map. Each item is one
// bus event or one local access and gives one result item. A bus read (reader
// start or transmit request) and a local read pass through an extra state for
// the registered read of the register map. A stop that ends a write packet
// copies the bytes after the first from the receive store into the map one
// byte per cycle through the map's single write port, from the address that
// the first byte gives. The result sits in an output register, so the next
// item is taken in the cycle the previous result leaves.

module i2c_slave_register_map_unit #(
	parameter int NUM_REGS = 32,
	parameter int RX_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  i2cmap_pkg::in_item_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output i2cmap_pkg::out_item_t result
);
	import i2cmap_pkg::*;

	ctl_t ctl;
	sts_t sts;

	i2cmap_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.ctl        (ctl)
	);

	i2cmap_dp #(
		.NUM_REGS (NUM_REGS),
		.RX_DEPTH (RX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while a previous one is still at work");

	a_one_map_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.map_rd_ptr, ctl.map_rd_local, ctl.map_wr_local, ctl.map_wr_burst}))
		else $error("more than one register map access in a cycle");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(result_valid && result_stall))
		else $error("result overwritten while stalled");

	a_cmd_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.command_valid |-> result.command_code[7])
		else $error("command reported without flag bit");

endmodule
